// ----- sv/itp_pkg.sv -----
// Shared constants, result type and operator priority for the infix to postfix converter.
// No dependencies.
`timescale 1ns / 1ps

package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STK_CW      = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_POW    = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;

  localparam logic [1:0] PRIO_NONE = 2'd0;
  localparam logic [1:0] PRIO_ADD  = 2'd1;
  localparam logic [1:0] PRIO_MUL  = 2'd2;
  localparam logic [1:0] PRIO_POW  = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       last;
    logic [1:0] error;
  } res_t;

  function automatic logic [1:0] prio(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CH_POW:         p = PRIO_POW;
      CH_MUL, CH_DIV: p = PRIO_MUL;
      CH_ADD, CH_SUB: p = PRIO_ADD;
      default:        p = PRIO_NONE;
    endcase
    return p;
  endfunction

endpackage

// ----- sv/itp_ifs.sv -----
// Valid/ready channel interfaces for the infix to postfix converter.
// No dependencies.
`timescale 1ns / 1ps

interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_expr;

  modport source (output valid, output ch, output end_of_expr, input ready);
  modport sink   (input valid, input ch, input end_of_expr, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic       last;
  logic [1:0] error;

  modport source (output valid, output out_char, output has_char, output last,
                  output error, input ready);
  modport sink   (input valid, input out_char, input has_char, input last,
                  input error, output ready);
endinterface

// ----- sv/infix_to_postfix_converter_top.sv -----
// Infix to postfix converter: operator stack in a local memory under a small sequencer.
// Depends on itp_pkg and the channel interfaces in itp_ifs.sv.
//
//   channel   dir  payload                               transfer when
//   in_chan   in   ch[7:0], end_of_expr                  valid && ready
//   out_chan  out  out_char[7:0], has_char, last, error  valid && ready
//
// An operand is emitted from S_IDLE and passes S_FIN, S_END and S_DRAIN; a '(' goes
// through S_PUSH first. Every stack inspection reads the stack memory in S_FETCH,
// then compares in S_CHECK, once per popped or examined entry, the end flush included.
// Reset (rst_n low, synchronous) empties the stack and drops pending results.
// A result waits in a hold register so that last can be set on it; the sequencer
// stalls an emit while hold and output are both full and the output is not ready.
`timescale 1ns / 1ps

module infix_to_postfix_converter_top (
  input  logic          clk,
  input  logic          rst_n,
  itp_in_if.sink        in_chan,
  itp_out_if.source     out_chan
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_PUSH  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_ERR   = 3'd5;
  localparam logic [2:0] S_END   = 3'd6;
  localparam logic [2:0] S_DRAIN = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic [itp_pkg::STK_CW-1:0]  count_r, count_nxt;
  logic                        flush_r, flush_nxt;
  logic [7:0]                  ch_r, ch_nxt;
  logic                        fin_r, fin_nxt;
  logic [1:0]                  err_r, err_nxt;
  itp_pkg::res_t               hold_r, hold_nxt;
  logic                        hold_v_r, hold_v_nxt;
  itp_pkg::res_t               out_r, out_nxt;
  logic                        out_v_r, out_v_nxt;
  logic [7:0]                  rd_q_r;

  logic [7:0]                  stack_mem [itp_pkg::STACK_DEPTH];
  logic [itp_pkg::STK_CW-1:0]  top_idx;
  logic [itp_pkg::STK_AW-1:0]  rd_addr;
  logic [itp_pkg::STK_AW-1:0]  wr_addr;
  logic                        mem_we;

  logic                        out_free;
  logic                        push_ok;
  logic                        emit_req;
  itp_pkg::res_t               emit_res;

  assign top_idx  = count_r - itp_pkg::STK_CW'(1);
  assign rd_addr  = top_idx[itp_pkg::STK_AW-1:0];
  assign wr_addr  = count_r[itp_pkg::STK_AW-1:0];
  assign out_free = !out_v_r || out_chan.ready;
  assign push_ok  = !hold_v_r || out_free;

  assign in_chan.ready     = (state_r == S_IDLE);
  assign out_chan.valid    = out_v_r;
  assign out_chan.out_char = out_r.out_char;
  assign out_chan.has_char = out_r.has_char;
  assign out_chan.last     = out_r.last;
  assign out_chan.error    = out_r.error;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    flush_nxt  = flush_r;
    ch_nxt     = ch_r;
    fin_nxt    = fin_r;
    err_nxt    = err_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && !out_chan.ready;
    mem_we     = 1'b0;
    emit_req   = 1'b0;
    emit_res   = '{out_char: rd_q_r, has_char: 1'b1, last: 1'b0,
                   error: itp_pkg::ERR_NONE};

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          ch_nxt  = in_chan.ch;
          fin_nxt = in_chan.end_of_expr;
          if (in_chan.ch == itp_pkg::CH_LPAREN) begin
            state_nxt = S_PUSH;
          end else if (in_chan.ch == itp_pkg::CH_RPAREN ||
                       itp_pkg::prio(in_chan.ch) != itp_pkg::PRIO_NONE) begin
            state_nxt = S_FETCH;
          end else begin
            emit_req          = 1'b1;
            emit_res.out_char = in_chan.ch;
            state_nxt         = S_FIN;
          end
        end
      end
      S_FETCH: begin
        if (count_r == '0) begin
          if (flush_r) begin
            state_nxt = S_END;
          end else if (ch_r == itp_pkg::CH_RPAREN) begin
            err_nxt   = itp_pkg::ERR_UNMATCHED;
            state_nxt = S_ERR;
          end else begin
            state_nxt = S_PUSH;
          end
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (flush_r) begin
          if (push_ok) begin
            emit_req  = 1'b1;
            count_nxt = top_idx;
            state_nxt = S_FETCH;
          end
        end else if (ch_r == itp_pkg::CH_RPAREN) begin
          if (rd_q_r == itp_pkg::CH_LPAREN) begin
            count_nxt = top_idx;
            state_nxt = S_FIN;
          end else if (push_ok) begin
            emit_req  = 1'b1;
            count_nxt = top_idx;
            state_nxt = S_FETCH;
          end
        end else if (itp_pkg::prio(rd_q_r) >= itp_pkg::prio(ch_r)) begin
          if (push_ok) begin
            emit_req  = 1'b1;
            count_nxt = top_idx;
            state_nxt = S_FETCH;
          end
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (count_r >= itp_pkg::STK_CW'(itp_pkg::STACK_DEPTH)) begin
          err_nxt   = itp_pkg::ERR_OVERFLOW;
          state_nxt = S_ERR;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + itp_pkg::STK_CW'(1);
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_r) begin
          flush_nxt = 1'b1;
          state_nxt = S_FETCH;
        end else begin
          state_nxt = S_END;
        end
      end
      S_ERR: begin
        if (push_ok) begin
          emit_req = 1'b1;
          emit_res = '{out_char: 8'h00, has_char: 1'b0, last: 1'b1, error: err_r};
          count_nxt = '0;
          flush_nxt = 1'b0;
          state_nxt = S_DRAIN;
        end
      end
      S_END: begin
        flush_nxt = 1'b0;
        if (fin_r) begin
          if (hold_v_r) begin
            hold_nxt.last = 1'b1;
          end else begin
            hold_nxt   = '{out_char: 8'h00, has_char: 1'b0, last: 1'b1,
                           error: itp_pkg::ERR_NONE};
            hold_v_nxt = 1'b1;
          end
        end
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_nxt    = hold_r;
          out_v_nxt  = 1'b1;
          hold_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit_req) begin
      if (hold_v_r) begin
        out_nxt   = hold_r;
        out_v_nxt = 1'b1;
      end
      hold_nxt   = emit_res;
      hold_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= ch_r;
    end
    rd_q_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      flush_r  <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      flush_r  <= flush_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    fin_r  <= fin_nxt;
    err_r  <= err_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

endmodule
